/* hw/rtl/rc4sc_pkg.sv */
// rc4 stream cipher core: shared constants, control word type and microcode rom
`default_nettype none

package rc4sc_pkg;

    localparam int PERM_DEPTH = 256;
    localparam int KEY_DEPTH  = 256;
    localparam logic [8:0] MAX_KEY_LEN = 9'd256;

    localparam int PC_W = 4;

    // step addresses
    localparam logic [PC_W-1:0] ST_RST_INIT = 4'd0;
    localparam logic [PC_W-1:0] ST_IDLE     = 4'd1;
    localparam logic [PC_W-1:0] ST_KINIT    = 4'd2;
    localparam logic [PC_W-1:0] ST_KRD      = 4'd3;
    localparam logic [PC_W-1:0] ST_KJ       = 4'd4;
    localparam logic [PC_W-1:0] ST_KW1      = 4'd5;
    localparam logic [PC_W-1:0] ST_KW2      = 4'd6;
    localparam logic [PC_W-1:0] ST_KEND     = 4'd7;
    localparam logic [PC_W-1:0] ST_P1       = 4'd8;
    localparam logic [PC_W-1:0] ST_P2       = 4'd9;
    localparam logic [PC_W-1:0] ST_P3       = 4'd10;
    localparam logic [PC_W-1:0] ST_P4       = 4'd11;
    localparam logic [PC_W-1:0] ST_P5       = 4'd12;
    localparam logic [PC_W-1:0] ST_P6       = 4'd13;

    // sequencer conditions
    localparam logic [2:0] COND_NEXT     = 3'd0;
    localparam logic [2:0] COND_JUMP     = 3'd1;
    localparam logic [2:0] COND_LOOP_K   = 3'd2;
    localparam logic [2:0] COND_OUT_BUSY = 3'd3;
    localparam logic [2:0] COND_DISPATCH = 3'd4;

    // index register operations
    localparam logic [2:0] IX_HOLD = 3'd0;
    localparam logic [2:0] IX_CLR  = 3'd1;
    localparam logic [2:0] IX_INC  = 3'd2;
    localparam logic [2:0] IX_KSA  = 3'd3;
    localparam logic [2:0] IX_PRGA = 3'd4;
    localparam logic [2:0] IX_END  = 3'd5;

    // permutation read address select
    localparam logic [2:0] RA_K    = 3'd0;
    localparam logic [2:0] RA_JKSA = 3'd1;
    localparam logic [2:0] RA_INC  = 3'd2;
    localparam logic [2:0] RA_JPR  = 3'd3;
    localparam logic [2:0] RA_T    = 3'd4;

    // permutation write select (address, data)
    localparam logic [1:0] WS_IDENT = 2'd0;
    localparam logic [1:0] WS_KSRD  = 2'd1;
    localparam logic [1:0] WS_JSI   = 2'd2;
    localparam logic [1:0] WS_ISRD  = 2'd3;

    typedef struct packed {
        logic            in_rdy;
        logic            k_inc;
        logic            kidx_clr;
        logic            cnt_clr;
        logic [2:0]      i_op;
        logic [2:0]      j_op;
        logic            si_ld;
        logic            sj_ld;
        logic [2:0]      ra_sel;
        logic            s_we;
        logic [1:0]      w_sel;
        logic            out_ld;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic mode;
        logic last_key;
        logic k_last;
        logic out_busy;
    } status_t;

    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '0;
        case (pc)
            ST_RST_INIT:
            begin
                w.k_inc  = 1'b1;
                w.s_we   = 1'b1;
                w.w_sel  = WS_IDENT;
                w.cond   = COND_LOOP_K;
                w.target = ST_RST_INIT;
            end
            ST_IDLE:
            begin
                w.in_rdy = 1'b1;
                w.cond   = COND_DISPATCH;
            end
            ST_KINIT:
            begin
                w.k_inc    = 1'b1;
                w.kidx_clr = 1'b1;
                w.j_op     = IX_CLR;
                w.s_we     = 1'b1;
                w.w_sel    = WS_IDENT;
                w.cond     = COND_LOOP_K;
                w.target   = ST_KINIT;
            end
            ST_KRD:
            begin
                w.ra_sel = RA_K;
            end
            ST_KJ:
            begin
                w.j_op   = IX_KSA;
                w.si_ld  = 1'b1;
                w.ra_sel = RA_JKSA;
            end
            ST_KW1:
            begin
                w.s_we  = 1'b1;
                w.w_sel = WS_KSRD;
            end
            ST_KW2:
            begin
                w.s_we   = 1'b1;
                w.w_sel  = WS_JSI;
                w.k_inc  = 1'b1;
                w.cond   = COND_LOOP_K;
                w.target = ST_KRD;
            end
            ST_KEND:
            begin
                w.cnt_clr = 1'b1;
                w.i_op    = IX_CLR;
                w.j_op    = IX_CLR;
                w.cond    = COND_JUMP;
                w.target  = ST_IDLE;
            end
            ST_P1:
            begin
                w.i_op   = IX_INC;
                w.ra_sel = RA_INC;
            end
            ST_P2:
            begin
                w.j_op   = IX_PRGA;
                w.si_ld  = 1'b1;
                w.ra_sel = RA_JPR;
            end
            ST_P3:
            begin
                w.sj_ld = 1'b1;
                w.s_we  = 1'b1;
                w.w_sel = WS_ISRD;
            end
            ST_P4:
            begin
                w.s_we  = 1'b1;
                w.w_sel = WS_JSI;
            end
            ST_P5:
            begin
                w.ra_sel = RA_T;
            end
            ST_P6:
            begin
                w.ra_sel = RA_T;
                w.out_ld = 1'b1;
                w.i_op   = IX_END;
                w.j_op   = IX_END;
                w.cond   = COND_OUT_BUSY;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.cond   = COND_JUMP;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/rc4sc_ram.sv */
// generic single write port ram with registered read
`default_nettype none

module rc4sc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/rc4sc_seq.sv */
// microcode sequencer: step counter, control rom and branch logic
`default_nettype none

module rc4sc_seq
    import rc4sc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire status_t status,
    output ctrl_t        ctrl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic [PC_W-1:0] pc_inc;

    assign ctrl   = ucode_rom(pc_reg);
    assign pc_inc = pc_reg + 4'd1;

    always_comb
    begin
        case (ctrl.cond)
            COND_NEXT:     pc_next = pc_inc;
            COND_JUMP:     pc_next = ctrl.target;
            COND_LOOP_K:   pc_next = status.k_last ? pc_inc : ctrl.target;
            COND_OUT_BUSY: pc_next = status.out_busy ? pc_reg : ctrl.target;
            COND_DISPATCH:
            begin
                if (status.accept && status.mode)
                begin
                    pc_next = ST_P1;
                end
                else if (status.accept && status.last_key)
                begin
                    pc_next = ST_KINIT;
                end
                else
                begin
                    pc_next = pc_reg;
                end
            end
            default:       pc_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_RST_INIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rc4sc_dp.sv */
// datapath: permutation and key memories, index registers, output register
`default_nettype none

module rc4sc_dp
    import rc4sc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire ctrl_t      ctrl,
    output status_t         status,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       mode,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_key,
    input  wire logic       message_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] out_byte
);

    logic [7:0] k_reg,    k_next;
    logic [7:0] kidx_reg, kidx_next;
    logic [8:0] cnt_reg,  cnt_next;
    logic [7:0] i_reg,    i_next;
    logic [7:0] j_reg,    j_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] si_reg;
    logic [7:0] sj_reg;
    logic [7:0] byte_reg;
    logic       mend_reg;
    logic [7:0] out_byte_reg;

    logic       accept;
    logic       busy;
    logic       fire;
    logic [7:0] s_rdata;
    logic [7:0] k_rdata;
    logic [7:0] s_raddr;
    logic [7:0] s_waddr;
    logic [7:0] s_wdata;
    logic       key_we;
    logic [8:0] n_eff;
    logic       kidx_wrap;
    logic [7:0] j_ksa;
    logic [7:0] j_prga;
    logic [7:0] i_inc;
    logic [7:0] t_idx;

    assign in_ready  = ctrl.in_rdy;
    assign accept    = in_valid && ctrl.in_rdy;
    assign busy      = out_valid_reg && !out_ready;
    assign fire      = !((ctrl.cond == COND_OUT_BUSY) && busy);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    assign status.accept   = accept;
    assign status.mode     = mode;
    assign status.last_key = last_key;
    assign status.k_last   = (k_reg == 8'hFF);
    assign status.out_busy = busy;

    assign j_ksa  = j_reg + s_rdata + k_rdata;
    assign j_prga = j_reg + s_rdata;
    assign i_inc  = i_reg + 8'd1;
    assign t_idx  = si_reg + sj_reg;

    assign n_eff     = (cnt_reg == 9'd0) ? 9'd1 : cnt_reg;
    assign kidx_wrap = (({1'b0, kidx_reg} + 9'd1) == n_eff);
    assign key_we    = accept && !mode && (cnt_reg < MAX_KEY_LEN);

    always_comb
    begin
        case (ctrl.ra_sel)
            RA_K:    s_raddr = k_reg;
            RA_JKSA: s_raddr = j_ksa;
            RA_INC:  s_raddr = i_inc;
            RA_JPR:  s_raddr = j_prga;
            RA_T:    s_raddr = t_idx;
            default: s_raddr = k_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.w_sel)
            WS_IDENT:
            begin
                s_waddr = k_reg;
                s_wdata = k_reg;
            end
            WS_KSRD:
            begin
                s_waddr = k_reg;
                s_wdata = s_rdata;
            end
            WS_JSI:
            begin
                s_waddr = j_reg;
                s_wdata = si_reg;
            end
            WS_ISRD:
            begin
                s_waddr = i_reg;
                s_wdata = s_rdata;
            end
            default:
            begin
                s_waddr = k_reg;
                s_wdata = k_reg;
            end
        endcase
    end

    rc4sc_ram #(
        .WIDTH (8),
        .DEPTH (PERM_DEPTH)
    ) u_perm_ram (
        .clk   (clk),
        .we    (ctrl.s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    rc4sc_ram #(
        .WIDTH (8),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (cnt_reg[7:0]),
        .wdata (data_byte),
        .raddr (kidx_reg),
        .rdata (k_rdata)
    );

    always_comb
    begin
        k_next = ctrl.k_inc ? (k_reg + 8'd1) : k_reg;

        if (ctrl.kidx_clr)
        begin
            kidx_next = 8'd0;
        end
        else if (ctrl.k_inc)
        begin
            kidx_next = kidx_wrap ? 8'd0 : (kidx_reg + 8'd1);
        end
        else
        begin
            kidx_next = kidx_reg;
        end

        if (ctrl.cnt_clr)
        begin
            cnt_next = 9'd0;
        end
        else if (key_we)
        begin
            cnt_next = cnt_reg + 9'd1;
        end
        else
        begin
            cnt_next = cnt_reg;
        end

        case (ctrl.i_op)
            IX_CLR:  i_next = 8'd0;
            IX_INC:  i_next = i_inc;
            IX_END:  i_next = (fire && mend_reg) ? 8'd0 : i_reg;
            default: i_next = i_reg;
        endcase

        case (ctrl.j_op)
            IX_CLR:  j_next = 8'd0;
            IX_KSA:  j_next = j_ksa;
            IX_PRGA: j_next = j_prga;
            IX_END:  j_next = (fire && mend_reg) ? 8'd0 : j_reg;
            default: j_next = j_reg;
        endcase

        if (ctrl.out_ld && fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg         <= 8'd0;
            kidx_reg      <= 8'd0;
            cnt_reg       <= 9'd0;
            i_reg         <= 8'd0;
            j_reg         <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            k_reg         <= k_next;
            kidx_reg      <= kidx_next;
            cnt_reg       <= cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.si_ld)
        begin
            si_reg <= s_rdata;
        end
        if (ctrl.sj_ld)
        begin
            sj_reg <= s_rdata;
        end
        if (accept)
        begin
            byte_reg <= data_byte;
            mend_reg <= message_end;
        end
        if (ctrl.out_ld && fire)
        begin
            out_byte_reg <= byte_reg ^ s_rdata;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rc4_stream_cipher_core.sv */
// rc4 stream cipher core top level
//
// channel  signals                                        direction
// in       in_valid, in_ready, mode, data_byte,           word in
//          last_key, message_end
// out      out_valid, out_ready, out_byte                 word out
//
// key word: stored in the key ram; the word flagged last_key then runs key
//   scheduling, an identity fill and then a read, j update and two swap writes per entry
// data word: runs steps p1 to p6 in turn, as the permutation ram has a single read port
// after reset an identity fill of all 256 entries runs before the first word is taken
// the last data step holds while the output register is full and not taken
`default_nettype none

module rc4_stream_cipher_core
    import rc4sc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       mode,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_key,
    input  wire logic       message_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] out_byte
);

    ctrl_t   ctrl;
    status_t status;

    rc4sc_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    rc4sc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .status      (status),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .data_byte   (data_byte),
        .last_key    (last_key),
        .message_end (message_end),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte)
    );

endmodule

`default_nettype wire
